// ===== hdl/wptd_pkg.sv =====
// package for the waypoint turn-then-drive controller
// holds payload structs, phase codes, cordic angle table and shared widths
`timescale 1ns / 1ps

package wptd_pkg;

  localparam int PosW   = 20;
  localparam int DiffW  = 21;
  localparam int D2W    = 43;
  localparam int CxW    = 48;
  localparam int ZW     = 32;
  localparam int AtanLen = 24;

  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhTurn    = 3'd1;
  localparam logic [2:0] PhFast    = 3'd2;
  localparam logic [2:0] PhSlow    = 3'd3;
  localparam logic [2:0] PhRealign = 3'd4;

  localparam logic [2:0] CfgAngTol  = 3'd0;
  localparam logic [2:0] CfgTurn    = 3'd1;
  localparam logic [2:0] CfgCruise  = 3'd2;
  localparam logic [2:0] CfgSlowFr  = 3'd3;
  localparam logic [2:0] CfgSlowRng = 3'd4;
  localparam logic [2:0] CfgArrTol  = 3'd5;

  typedef struct packed {
    logic                   cmd;
    logic signed [19:0]     goal_x;
    logic signed [19:0]     goal_y;
    logic signed [19:0]     pose_x;
    logic signed [19:0]     pose_y;
    logic signed [15:0]     pose_yaw;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic               arrived;
    logic [2:0]         phase_now;
  } out_word_t;

  // control between sequencer and cordic
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } cordic_ctl_t;

  function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
    logic [ZW-1:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41721;
      5'd15: v = 32'd20860;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2607;
      5'd19: v = 32'd1303;
      5'd20: v = 32'd651;
      5'd21: v = 32'd325;
      5'd22: v = 32'd162;
      5'd23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/wptd_cordic.sv =====
// iterative cordic vectoring unit, one micro-rotation per cycle
// depends on wptd_pkg for widths and the angle table
`timescale 1ns / 1ps

module wptd_cordic import wptd_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DiffW-1:0] dx,
  input  logic signed [DiffW-1:0] dy,
  output logic                    done,
  output logic [15:0]             heading
);

  localparam int CntW = $clog2(CORDIC_STEPS + 1);

  logic signed [CxW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [ZW-1:0]         z_r, z_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic                  zero_r, zero_nxt;
  logic signed [CxW-1:0] xs, ys;
  logic signed [CxW-1:0] ax, ay;
  logic [ZW-1:0]         zr;

  // sign-extend and pre-rotate into the right half plane
  always_comb begin
    ax = CxW'(dx) <<< 24;
    ay = CxW'(dy) <<< 24;
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    cnt_nxt = cnt_r; run_nxt = run_r; done_nxt = 1'b0; zero_nxt = zero_r;
    if (start) begin
      zero_nxt = (dx == '0) && (dy == '0);
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
      if (dx < 0) begin
        x_nxt = -ax; y_nxt = -ay; z_nxt = 32'h8000_0000;
      end else begin
        x_nxt = ax; y_nxt = ay; z_nxt = '0;
      end
    end else if (run_r) begin
      // one micro-rotation
      if (y_r >= 0) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + atan_lut(5'(cnt_r));
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - atan_lut(5'(cnt_r));
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(CORDIC_STEPS - 1)) begin
        run_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; zero_r <= zero_nxt;
    if (!rst_n) begin
      cnt_r <= '0; run_r <= 1'b0; done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; run_r <= run_nxt; done_r <= done_nxt;
    end
  end

  // round to 16 bit angle
  assign zr      = z_r + 32'h0000_8000;
  assign heading = zero_r ? 16'd0 : zr[31:16];
  assign done    = done_r;

endmodule

// ===== hdl/waypoint_turn_then_drive_controller.sv =====
// top level of the waypoint turn-then-drive controller: sequencer and output word
// depends on wptd_pkg and wptd_cordic
`timescale 1ns / 1ps
//
// Usage:
//   in_valid/in_stall/in_data carry one pose reading word; cmd=1 also loads a
//   new waypoint. out_valid/out_stall/out_data carry one drive command word
//   per reading. cfg_we/cfg_index/cfg_data write the six tuning registers.
// Sequencing:
//   a reading that needs no heading passes through the squared distance and
//   thresholds on a shared 23x23 multiplier, then the phase decision. A new
//   waypoint also waits for the iterative cordic unit to compute the heading,
//   and a slow-phase overshoot recomputes the heading before it realigns. One
//   reading is in flight at a time; in_stall is high from acceptance until the
//   result word has been loaded into the output register.
// Reset: phase idle, target and heading zero, registers to their defaults.
// Receiver stall: the result word holds in the output register; a finished
//   reading waits until the output register is free, and the input stays
//   stalled meanwhile.
//

module waypoint_turn_then_drive_controller import wptd_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HEAD  = 7'b0000010,
    S_MULX  = 7'b0000100,
    S_MULY  = 7'b0001000,
    S_THR   = 7'b0010000,
    S_DEC   = 7'b0100000,
    S_WAIT  = 7'b1000000
  } st_t;

  st_t st_r, st_nxt;

  logic [13:0] ang_tol_r;
  logic [14:0] turn_r, cruise_r;
  logic [7:0]  slowfr_r;
  logic [19:0] slowrng_r, arrtol_r;

  logic [2:0]              phase_r, phase_nxt;
  logic [15:0]             hgoal_r, hgoal_nxt;
  logic signed [PosW-1:0]  tx_r, tx_nxt, ty_r, ty_nxt;
  in_word_t                in_r;
  logic signed [DiffW-1:0] dx_r, dy_r;
  logic [D2W-1:0]          d2_r, d2_nxt;
  logic [39:0]             sr2_r, at2_r;
  logic [22:0]             slowspd_r;
  logic                    recalc_r, recalc_nxt;
  logic [1:0]              thr_r, thr_nxt;
  out_word_t               ob_r, ob_nxt;
  logic                    ov_r, ov_nxt;

  // shared multiplier operands
  logic [22:0] ma, mb;
  logic [45:0] mp;
  logic        start_c, cdone;
  logic [15:0] cheading;
  logic signed [DiffW-1:0] cdx, cdy;
  logic signed [DiffW-1:0] adx, ady;

  wptd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(start_c), .dx(cdx), .dy(cdy),
    .done(cdone), .heading(cheading)
  );

  assign adx = dx_r[DiffW-1] ? -dx_r : dx_r;
  assign ady = dy_r[DiffW-1] ? -dy_r : dy_r;
  assign cdx = dx_r;
  assign cdy = dy_r;

  // operand select for the multiplier
  always_comb begin
    unique case (1'b1)
      st_r[0]: begin ma = 23'(cruise_r); mb = 23'(slowfr_r); end
      st_r[2]: begin ma = 23'(adx); mb = 23'(adx); end
      st_r[3]: begin ma = 23'(ady); mb = 23'(ady); end
      default: begin
        ma = (thr_r == 2'd0) ? 23'(slowrng_r) : 23'(arrtol_r);
        mb = ma;
      end
    endcase
    mp = ma * mb;
  end

  // heading error check
  logic [15:0] err;
  logic [15:0] emag;
  logic        turn_need;
  logic        beyond_sr, beyond_at;
  assign err       = hgoal_r - in_r.pose_yaw;
  assign emag      = err[15] ? -err : err;
  assign turn_need = {1'b0, emag} > {3'b0, ang_tol_r};
  assign beyond_sr = {5'b0, d2_r} > {8'b0, sr2_r};
  assign beyond_at = {5'b0, d2_r} > {8'b0, at2_r};

  always_comb begin
    logic [2:0] ph;
    out_word_t  o;
    ph = phase_r;
    o  = '0;
    st_nxt = st_r; phase_nxt = phase_r; hgoal_nxt = hgoal_r;
    tx_nxt = tx_r; ty_nxt = ty_r; d2_nxt = d2_r; recalc_nxt = recalc_r;
    thr_nxt = thr_r; ob_nxt = ob_r; ov_nxt = ov_r; start_c = 1'b0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.cmd) begin
            tx_nxt = in_data.goal_x; ty_nxt = in_data.goal_y;
            phase_nxt = PhTurn;
          end
          recalc_nxt = in_data.cmd;
          st_nxt = S_MULX;
        end
      end
      S_MULX: begin
        d2_nxt = D2W'(mp);
        if (recalc_r) start_c = 1'b1;
        st_nxt = S_MULY;
      end
      S_MULY: begin
        d2_nxt = d2_r + D2W'(mp);
        thr_nxt = 2'd0;
        st_nxt = S_THR;
      end
      S_THR: begin
        thr_nxt = thr_r + 2'd1;
        if (thr_r == 2'd1) st_nxt = recalc_r ? S_HEAD : S_DEC;
      end
      S_HEAD: begin
        if (cdone) begin
          hgoal_nxt = cheading;
          recalc_nxt = 1'b0;
          st_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (ph == PhSlow && beyond_sr && beyond_at) begin
          // overshoot: recompute heading then realign
          start_c = 1'b1; recalc_nxt = 1'b1; phase_nxt = PhRealign;
          st_nxt = S_HEAD;
        end else begin
          priority if (ph == PhTurn || ph == PhRealign) begin
            if (turn_need) begin
              o.angular_cmd = err[15] ? -16'(turn_r) : 16'(turn_r);
            end else if (ph == PhTurn && beyond_sr) begin
              ph = PhFast; o.linear_cmd = 16'(cruise_r);
            end else if (!beyond_at) begin
              ph = PhIdle; o.arrived = 1'b1;
            end else begin
              ph = PhSlow; o.linear_cmd = 16'(slowspd_r[22:8]);
            end
          end else if (ph == PhFast) begin
            if (beyond_sr) o.linear_cmd = 16'(cruise_r);
            else if (!beyond_at) begin ph = PhIdle; o.arrived = 1'b1; end
            else begin ph = PhSlow; o.linear_cmd = 16'(slowspd_r[22:8]); end
          end else if (ph == PhSlow) begin
            if (!beyond_at) begin ph = PhIdle; o.arrived = 1'b1; end
            else o.linear_cmd = 16'(slowspd_r[22:8]);
          end else begin
            ph = PhIdle;
          end
          o.phase_now = ph;
          phase_nxt = ph;
          st_nxt = S_WAIT;
          ob_nxt = o;
        end
      end
      S_WAIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_WAIT && (!ov_r || !out_stall)) ob_nxt = ob_r;
  end

  // output register loads only when free
  out_word_t obuf_r;
  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    if (st_r == S_WAIT && (!ov_r || !out_stall)) obuf_r <= ob_r;
    if (st_r == S_IDLE && in_valid) begin
      in_r <= in_data;
      dx_r <= (in_data.cmd ? DiffW'(in_data.goal_x) : DiffW'(tx_r)) - DiffW'(in_data.pose_x);
      dy_r <= (in_data.cmd ? DiffW'(in_data.goal_y) : DiffW'(ty_r)) - DiffW'(in_data.pose_y);
    end
    d2_r <= d2_nxt;
    if (st_r == S_THR) begin
      if (thr_r == 2'd0) sr2_r <= mp[39:0];
      else at2_r <= mp[39:0];
    end
    if (st_r == S_IDLE) slowspd_r <= mp[22:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; phase_r <= PhIdle; hgoal_r <= '0; tx_r <= '0; ty_r <= '0;
      recalc_r <= 1'b0; thr_r <= '0; ov_r <= 1'b0;
      ang_tol_r <= 14'd1820; turn_r <= 15'd4096; cruise_r <= 15'd8192;
      slowfr_r <= 8'd128; slowrng_r <= 20'd500; arrtol_r <= 20'd100;
    end else begin
      st_r <= st_nxt; phase_r <= phase_nxt; hgoal_r <= hgoal_nxt;
      tx_r <= tx_nxt; ty_r <= ty_nxt; recalc_r <= recalc_nxt;
      thr_r <= thr_nxt; ov_r <= ov_nxt;
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CfgAngTol:  ang_tol_r <= cfg_data[13:0];
          CfgTurn:    turn_r    <= cfg_data[14:0];
          CfgCruise:  cruise_r  <= cfg_data[14:0];
          CfgSlowFr:  slowfr_r  <= cfg_data[7:0];
          CfgSlowRng: slowrng_r <= cfg_data;
          CfgArrTol:  arrtol_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = obuf_r;

endmodule
